[sv/assert_macros.svh]
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies a consequence on the same edge.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check that a condition implies a consequence on the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[sv/sov_pkg.sv]
// Package with the types and constants of the octant visibility block.
package sov_pkg;
  localparam int unsigned RowW = 8;
  localparam int unsigned DistW = 9;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_B,
    ST_DIV_E,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_DECIDE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_WRITE,
    ST_FULL_RD,
    ST_FULL_WAIT,
    ST_OUT
  } sov_state_e;

  typedef struct packed {
    logic start;
    logic busy;
  } sov_div_ctl_t;
endpackage

[sv/sov_ram.sv]
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module sov_ram #(
  parameter int unsigned Width = 17,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[sv/sov_div.sv]
// Restoring divider producing one quotient bit a cycle, saturating.
module sov_div #(
  parameter int unsigned NumW  = 9,
  parameter int unsigned DenW  = 9,
  parameter int unsigned FracW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NumW-1:0]      num_i,
  input  logic [DenW-1:0]      den_i,
  output sov_pkg::sov_div_ctl_t ctl_o,
  output logic                 done_o,
  output logic [FracW:0]       quo_o
);
  import sov_pkg::*;

  localparam int unsigned QW = NumW + FracW;
  localparam int unsigned CntW = $clog2(QW + 1);

  logic [QW-1:0]   dvd_q, dvd_d;
  logic [QW-1:0]   quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW:0]   trial;

  always_comb begin
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenW-1:0], dvd_q[QW-1]};
    if (start_i) begin
      dvd_d  = {num_i, {FracW{1'b0}}};
      quo_d  = '0;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(QW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign ctl_o.start = start_i;
  assign ctl_o.busy  = busy_q;
  assign done_o      = done_q;
  assign quo_o = (|quo_q[QW-1:FracW+1]) ? {(FracW+1){1'b1}} : quo_q[FracW:0];
endmodule

[sv/shadowcast_octant_visibility.sv]
// Top level of the shadowcasting octant visibility block.
// Use: feed the tiles of one octant in scan order on the tile channel
// (tile_valid_i / tile_stall_o); set new_octant_i on the first tile of each
// octant to clear the shadow list. One result beat per tile leaves on the
// result channel (res_valid_o / res_stall_i) carrying visible, full_shadow
// and list_overflow.
// Flow: two serial divisions (25 quotient bits each) on one shared divider,
// then a scan of the shadow list (one RAM read per stored interval), an
// insertion shift or a pull-down after a join (one read and one write per
// moved interval) and a full-shadow check.
// One tile is worked at a time; the tile channel stalls while busy.
// Receiver stall: the result beat holds in the output register until taken;
// the next tile is accepted in the same cycle the result is taken.
// Reset: shadow count and full flag clear, max_distance returns to 256.
// The interval RAMs are not cleared; only entries below the count are read.
// The user writes max_distance on the cfg channel (always ready) only while idle; the block does not enforce it.
module shadowcast_octant_visibility #(
  parameter int unsigned MaxShadows = 128,
  parameter int unsigned MaxRadius  = 255,
  parameter int unsigned FracBits   = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [8:0] cfg_data_i,
  input  logic       tile_valid_i,
  output logic       tile_stall_o,
  input  logic       new_octant_i,
  input  logic [7:0] tile_row_i,
  input  logic [7:0] tile_col_i,
  input  logic       opaque_tile_i,
  output logic       res_valid_o,
  input  logic       res_stall_i,
  output logic       visible_o,
  output logic       full_shadow_o,
  output logic       list_overflow_o
);
  import sov_pkg::*;

  localparam int unsigned SW = FracBits + 1;
  localparam int unsigned AW = $clog2(MaxShadows);
  localparam int unsigned CW = $clog2(MaxShadows + 1);
  localparam int unsigned RadW = $clog2(MaxRadius + 1) + 1;
  localparam logic [SW-1:0] LowThr = SW'((64'd1 << FracBits) / 64'd1000);
  localparam logic [SW-1:0] HighThr =
    SW'(((64'd1 << FracBits) * 64'd999 + 64'd999) / 64'd1000);

  sov_state_e state_q, state_d;
  logic [DistW-1:0] maxd_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic blocked_q, blocked_d;
  logic [RowW-1:0] row_q, col_q;
  logic opq_q, newo_q;
  logic [SW-1:0] b_q, b_d, e_q, e_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] pos_q, pos_d;
  logic found_q, found_d;
  logic cov_q, cov_d;
  logic [SW-1:0] pend_q, pend_d;
  logic [SW-1:0] pbeg_q, pbeg_d;
  logic [SW-1:0] nbeg_q, nbeg_d, nend_q, nend_d;
  logic vis_q, vis_d, ovf_q, ovf_d;
  logic res_valid_q, res_valid_d;

  logic div_start, div_done;
  logic [RowW:0] div_num, div_den;
  logic [SW-1:0] div_quo;
  sov_div_ctl_t div_ctl;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [SW-1:0] wbeg, wend, rbeg, rend;
  logic [CW-1:0] cnt_eff;
  logic in_range;
  logic accept;

  assign accept = tile_valid_i && !tile_stall_o;
  assign cnt_eff = newo_q ? '0 : cnt_q;
  assign in_range = ({1'b0, row_q} < maxd_q) && (RadW'(row_q) <= RadW'(MaxRadius));

  sov_div #(.NumW(RowW + 1), .DenW(RowW + 1), .FracW(FracBits)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .ctl_o(div_ctl), .done_o(div_done), .quo_o(div_quo)
  );

  sov_ram #(.Width(SW), .Depth(MaxShadows)) u_beg (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wbeg), .raddr_i(raddr), .rdata_o(rbeg)
  );
  sov_ram #(.Width(SW), .Depth(MaxShadows)) u_end (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wend), .raddr_i(raddr), .rdata_o(rend)
  );

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    blocked_d = blocked_q;
    b_d = b_q;
    e_d = e_q;
    idx_d = idx_q;
    pos_d = pos_q;
    found_d = found_q;
    cov_d = cov_q;
    pend_d = pend_q;
    pbeg_d = pbeg_q;
    nbeg_d = nbeg_q;
    nend_d = nend_q;
    vis_d = vis_q;
    ovf_d = ovf_q;
    res_valid_d = res_valid_q;
    div_start = 1'b0;
    div_num = {1'b0, col_q};
    div_den = {1'b0, row_q} + 9'd2;
    we = 1'b0;
    waddr = '0;
    wbeg = b_q;
    wend = e_q;
    raddr = AW'(idx_q);
    if (res_valid_q && !res_stall_i) begin
      res_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DIV_B;
          div_start = 1'b1;
          div_num = {1'b0, tile_col_i};
          div_den = {1'b0, tile_row_i} + 9'd2;
        end
      end
      ST_DIV_B: begin
        if (div_done) begin
          b_d = div_quo;
          div_start = 1'b1;
          div_num = {1'b0, col_q} + 9'd1;
          div_den = {1'b0, row_q} + 9'd1;
          state_d = ST_DIV_E;
        end
      end
      ST_DIV_E: begin
        if (div_done) begin
          e_d = div_quo;
          if (newo_q) begin
            cnt_d = '0;
            blocked_d = 1'b0;
          end
          idx_d = '0;
          found_d = 1'b0;
          cov_d = 1'b0;
          pos_d = cnt_eff;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Read entry idx; all entries are scanned for cover and position.
        if (idx_q >= cnt_q) begin
          state_d = ST_DECIDE;
        end else begin
          state_d = ST_SCAN_WAIT;
        end
      end
      ST_SCAN_WAIT: begin
        if (rbeg <= b_q && rend >= e_q) cov_d = 1'b1;
        if (!found_q && rbeg >= b_q) begin
          found_d = 1'b1;
          pos_d = idx_q;
          nbeg_d = rbeg;
          nend_d = rend;
        end
        if (idx_q != '0 && !found_q && !(rbeg >= b_q)) begin
          pend_d = rend;
          pbeg_d = rbeg;
        end
        if (idx_q == '0 && !(rbeg >= b_q)) begin
          pend_d = rend;
          pbeg_d = rbeg;
        end
        idx_d = idx_q + 1'b1;
        state_d = ST_SCAN;
      end
      ST_DECIDE: begin
        vis_d = 1'b0;
        ovf_d = 1'b0;
        state_d = ST_OUT;
        if (in_range && !blocked_q && !cov_q) begin
          vis_d = 1'b1;
          if (opq_q) begin
            if ((pos_q != '0 && pend_q > b_q) && (pos_q < cnt_q && nbeg_q < e_q)) begin
              // Join previous and next, then pull the tail down by one.
              we = 1'b1;
              waddr = AW'(pos_q - 1'b1);
              wbeg = pbeg_q;
              wend = nend_q;
              idx_d = pos_q + 1'b1;
              found_d = 1'b0;
              state_d = ST_SHIFT_RD;
              b_d = '0;
            end else if (pos_q < cnt_q && nbeg_q < e_q) begin
              we = 1'b1;
              waddr = AW'(pos_q);
              wbeg = b_q;
              wend = nend_q;
              state_d = ST_FULL_RD;
            end else if (pos_q != '0 && pend_q > b_q) begin
              // Keep begin: read it back first.
              idx_d = pos_q - 1'b1;
              state_d = ST_WRITE;
            end else if (cnt_q >= CW'(MaxShadows)) begin
              ovf_d = 1'b1;
            end else begin
              idx_d = cnt_q;
              state_d = (cnt_q == pos_q) ? ST_FULL_RD : ST_SHIFT_RD;
              b_d = b_q;
              if (cnt_q == pos_q) begin
                we = 1'b1;
                waddr = AW'(pos_q);
                cnt_d = cnt_q + 1'b1;
              end
              found_d = 1'b1;
            end
          end
        end
      end
      ST_SHIFT_RD: begin
        // found_q marks an upward shift (insert); otherwise a downward pull.
        raddr = found_q ? AW'(idx_q - 1'b1) : AW'(idx_q);
        if (found_q ? (idx_q == pos_q) : (idx_q >= cnt_q)) begin
          if (found_q) begin
            we = 1'b1;
            waddr = AW'(pos_q);
            cnt_d = cnt_q + 1'b1;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
          state_d = ST_FULL_RD;
        end else begin
          state_d = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        we = 1'b1;
        wbeg = rbeg;
        wend = rend;
        if (found_q) begin
          waddr = AW'(idx_q);
          idx_d = idx_q - 1'b1;
        end else begin
          waddr = AW'(idx_q - 1'b1);
          idx_d = idx_q + 1'b1;
        end
        state_d = ST_SHIFT_RD;
      end
      ST_WRITE: begin
        // rbeg is valid in the cycle after the address was set.
        if (found_q) begin
          we = 1'b1;
          waddr = AW'(idx_q);
          wbeg = rbeg;
          wend = e_q;
          state_d = ST_FULL_RD;
        end else begin
          found_d = 1'b1;
        end
      end
      ST_FULL_RD: begin
        idx_d = '0;
        raddr = '0;
        state_d = ST_FULL_WAIT;
      end
      ST_FULL_WAIT: begin
        raddr = '0;
        blocked_d = (cnt_q == CW'(1)) && (rbeg <= LowThr) && (rend >= HighThr);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!res_valid_q || !res_stall_i) begin
          res_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      maxd_q <= 9'd256;
      cnt_q <= '0;
      blocked_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      blocked_q <= blocked_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) maxd_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q <= tile_row_i;
      col_q <= tile_col_i;
      opq_q <= opaque_tile_i;
      newo_q <= new_octant_i;
    end
    b_q <= b_d;
    e_q <= e_d;
    idx_q <= idx_d;
    pos_q <= pos_d;
    found_q <= (state_q == ST_DECIDE && state_d == ST_WRITE) ? 1'b0 : found_d;
    cov_q <= cov_d;
    pend_q <= pend_d;
    pbeg_q <= pbeg_d;
    nbeg_q <= nbeg_d;
    nend_q <= nend_d;
    if (state_q == ST_DECIDE) begin
      vis_q <= vis_d;
      ovf_q <= ovf_d;
    end
  end

  assign cfg_ready_o = 1'b1;
  // Stall tiles while one is in work or a result beat waits at the output.
  assign tile_stall_o = (state_q != ST_IDLE) || (res_valid_q && res_stall_i);
  assign res_valid_o = res_valid_q;
  assign visible_o = vis_q;
  assign full_shadow_o = blocked_q;
  assign list_overflow_o = ovf_q;

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CW'(MaxShadows))
  `ASSERT_IMPL(a_div_idle, clk_i, rst_ni, state_q == ST_IDLE, !div_ctl.busy)
  `ASSERT_NEXT(a_ovf_vis, clk_i, rst_ni, state_q == ST_DECIDE && ovf_d, vis_q)
endmodule

[verif/tb_shadowcast_octant_visibility.sv]
// Shadowcasting octant visibility testbench: directed table, distance sweep, random octants.
`timescale 1ns / 1ps

module tb_shadowcast_octant_visibility;

  localparam int unsigned ShadowSlots = 128;
  localparam int unsigned FracW       = 16;
  localparam int unsigned SpanW       = FracW + 1;
  localparam logic [SpanW-1:0] SpanSat = '1;
  // full-shadow thresholds: floor(0.001 * 2^16) and ceil(0.999 * 2^16)
  localparam logic [SpanW-1:0] FullLoThr = 17'd65;
  localparam logic [SpanW-1:0] FullHiThr = 17'd65471;
  localparam int unsigned DrainCycles = 700;
  localparam int unsigned StallLimit  = 20000;
  localparam int unsigned HoldCycles  = 3000;
  localparam int unsigned RandTiles   = 1400;

  typedef struct packed {
    logic       new_oct;
    logic [7:0] row;
    logic [7:0] col;
    logic       opq;
  } tile_req_t;

  typedef struct packed {
    logic vis;
    logic full;
    logic ovf;
  } tile_verdict_t;

  typedef struct packed {
    tile_req_t     req;
    logic          known;
    tile_verdict_t want;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [8:0] cfg_data_i;
  logic       tile_valid_i;
  logic       tile_stall_o;
  logic       new_octant_i;
  logic [7:0] tile_row_i;
  logic [7:0] tile_col_i;
  logic       opaque_tile_i;
  logic       res_valid_o;
  logic       res_stall_i;
  logic       visible_o;
  logic       full_shadow_o;
  logic       list_overflow_o;

  shadowcast_octant_visibility i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .tile_valid_i   (tile_valid_i),
    .tile_stall_o   (tile_stall_o),
    .new_octant_i   (new_octant_i),
    .tile_row_i     (tile_row_i),
    .tile_col_i     (tile_col_i),
    .opaque_tile_i  (opaque_tile_i),
    .res_valid_o    (res_valid_o),
    .res_stall_i    (res_stall_i),
    .visible_o      (visible_o),
    .full_shadow_o  (full_shadow_o),
    .list_overflow_o(list_overflow_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Shadow list mirror: sorted merged intervals plus the full-shadow flag.
  logic [SpanW-1:0] shade_lo [ShadowSlots];
  logic [SpanW-1:0] shade_hi [ShadowSlots];
  int unsigned      shade_cnt;
  logic             octant_dark;
  logic [8:0]       dist_lim;

  tile_verdict_t verdict_q[$];

  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned hold_left;
  int unsigned tiles_sent;
  int unsigned beats_seen;
  int unsigned vis_seen;
  int unsigned full_seen;
  int unsigned ovf_seen;
  int unsigned mismatch_cnt;
  int unsigned quiet_cycles;

  // Floored fixed-point quotient, saturated to the span width.
  function automatic logic [SpanW-1:0] span_quot(input int unsigned num, input int unsigned den);
    logic [31:0] q;
    q = (num << FracW) / den;
    return (q > 32'(SpanSat)) ? SpanSat : q[SpanW-1:0];
  endfunction

  // Advance the shadow mirror by one tile and return what the block should report.
  function automatic tile_verdict_t shade_tile(input tile_req_t t);
    logic [SpanW-1:0] b;
    logic [SpanW-1:0] e;
    int unsigned      pos;
    int unsigned      k;
    logic             hit;
    logic             prev_hit;
    logic             next_hit;
    tile_verdict_t    v;
    if (t.new_oct) begin
      shade_cnt   = 0;
      octant_dark = 1'b0;
    end
    b = span_quot(t.col, t.row + 2);
    e = span_quot(t.col + 1, t.row + 1);
    v = '0;
    hit = 1'b0;
    for (k = 0; k < shade_cnt; k++) begin
      if (shade_lo[k] <= b && shade_hi[k] >= e) hit = 1'b1;
    end
    if ({1'b0, t.row} < dist_lim && !octant_dark && !hit) begin
      v.vis = 1'b1;
      if (t.opq) begin
        for (pos = 0; pos < shade_cnt; pos++) begin
          if (shade_lo[pos] >= b) break;
        end
        prev_hit = (pos > 0) && (shade_hi[pos-1] > b);
        next_hit = (pos < shade_cnt) && (shade_lo[pos] < e);
        if (prev_hit && next_hit) begin
          // span bridges both neighbours: join them at the next one's end
          shade_hi[pos-1] = shade_hi[pos];
          for (k = pos; k + 1 < shade_cnt; k++) begin
            shade_lo[k] = shade_lo[k+1];
            shade_hi[k] = shade_hi[k+1];
          end
          shade_cnt--;
        end else if (next_hit) begin
          shade_lo[pos] = b;
        end else if (prev_hit) begin
          shade_hi[pos-1] = e;
        end else if (shade_cnt >= ShadowSlots) begin
          v.ovf = 1'b1;
        end else begin
          for (k = shade_cnt; k > pos; k--) begin
            shade_lo[k] = shade_lo[k-1];
            shade_hi[k] = shade_hi[k-1];
          end
          shade_lo[pos] = b;
          shade_hi[pos] = e;
          shade_cnt++;
        end
        octant_dark = (shade_cnt == 1) && (shade_lo[0] <= FullLoThr) &&
                      (shade_hi[0] >= FullHiThr);
      end
    end
    v.full = octant_dark;
    return v;
  endfunction

  // Offer one tile beat; called at a rising edge, returns at the edge that took it.
  task automatic send_tile(input tile_req_t t, input logic known, input tile_verdict_t want);
    tile_verdict_t v;
    if ($urandom_range(99) < snd_idle_pct) begin
      tile_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle_pct);
    end
    tile_valid_i  <= 1'b1;
    new_octant_i  <= t.new_oct;
    tile_row_i    <= t.row;
    tile_col_i    <= t.col;
    opaque_tile_i <= t.opq;
    do @(posedge clk_i); while (tile_stall_o);
    v = shade_tile(t);
    verdict_q.push_back(known ? want : v);
    tiles_sent++;
  endtask

  task automatic send_plain(input logic no, input int unsigned row, input int unsigned col,
                            input logic opq);
    send_tile({no, 8'(row), 8'(col), opq}, 1'b0, '0);
  endtask

  // Let the block go idle, then write max_distance.
  task automatic set_distance(input logic [8:0] lim);
    tile_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= lim;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    dist_lim = lim;
  endtask

  // Fill the list with 128 disjoint shadows on the last row, then force a drop.
  task automatic fill_list();
    int unsigned c;
    for (c = 0; c < 256; c += 2) send_plain(c == 0, 255, c, 1'b1);
    send_plain(1'b0, 127, 255, 1'b1);
    send_plain(1'b0, 200, 250, 1'b1);
  endtask

  // One octant in scan order; rows start at a random base so wide rows appear too.
  task automatic send_octant();
    int unsigned base;
    int unsigned depth;
    int unsigned r;
    int unsigned c;
    int unsigned opq_pct;
    int unsigned n;
    logic        first;
    base    = ($urandom_range(9) == 0) ? $urandom_range(254) : 0;
    depth   = $urandom_range(2, 12);
    opq_pct = $urandom_range(5, 60);
    first   = 1'b1;
    for (r = base; r <= base + depth && r < 256; r++) begin
      c = (r > 16) ? $urandom_range(r - 10) : 0;
      n = 0;
      while (c <= r && n < 14) begin
        // drop a tile now and then to break the scan
        if ($urandom_range(19) != 0) begin
          send_plain(first, r, c, $urandom_range(99) < opq_pct);
          first = 1'b0;
        end
        c += (r > 16) ? $urandom_range(1, 3) : 1;
        n++;
      end
    end
  endtask

  task automatic send_noise();
    send_plain($urandom_range(1), $urandom_range(255), $urandom_range(255), $urandom_range(1));
  endtask

  // Directed table; expectations typed in only where they are obvious.
  localparam int unsigned DirRows = 17;
  localparam dir_row_t DirTbl [DirRows] = '{
    '{'{1'b1, 8'd1,   8'd0,   1'b0}, 1'b1, '{1'b1, 1'b0, 1'b0}},  // first tile after reset
    '{'{1'b0, 8'd255, 8'd255, 1'b1}, 1'b0, '0},                   // far corner shadow
    '{'{1'b0, 8'd0,   8'd0,   1'b1}, 1'b1, '{1'b1, 1'b1, 1'b0}},  // row zero covers octant
    '{'{1'b0, 8'd3,   8'd1,   1'b1}, 1'b1, '{1'b0, 1'b1, 1'b0}},  // hidden after full shadow
    '{'{1'b1, 8'd1,   8'd0,   1'b1}, 1'b1, '{1'b1, 1'b0, 1'b0}},
    '{'{1'b0, 8'd1,   8'd1,   1'b1}, 1'b1, '{1'b1, 1'b1, 1'b0}},  // merge into full shadow
    '{'{1'b1, 8'd4,   8'd0,   1'b1}, 1'b0, '0},
    '{'{1'b0, 8'd4,   8'd4,   1'b1}, 1'b0, '0},
    '{'{1'b0, 8'd4,   8'd2,   1'b1}, 1'b0, '0},
    '{'{1'b0, 8'd4,   8'd1,   1'b1}, 1'b0, '0},                   // bridges two shadows
    '{'{1'b0, 8'd5,   8'd1,   1'b0}, 1'b0, '0},                   // inside a shadow
    '{'{1'b0, 8'd1,   8'd255, 1'b1}, 1'b0, '0},                   // column past row, saturates
    '{'{1'b0, 8'd128, 8'd170, 1'b0}, 1'b0, '0},
    '{'{1'b1, 8'd0,   8'd0,   1'b0}, 1'b1, '{1'b1, 1'b0, 1'b0}},
    '{'{1'b0, 8'd2,   8'd1,   1'b1}, 1'b0, '0},
    '{'{1'b0, 8'd2,   8'd0,   1'b1}, 1'b0, '0},
    '{'{1'b0, 8'd2,   8'd2,   1'b1}, 1'b0, '0}
  };

  // Result side: stall generator with a counted long hold-off.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      res_stall_i <= 1'b1;
    end else begin
      res_stall_i <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // Compare each taken result beat with the oldest expectation; watch for hangs.
  always @(posedge clk_i) begin
    tile_verdict_t want;
    tile_verdict_t got;
    if (rst_ni) begin
      if ((tile_valid_i && !tile_stall_o) || (res_valid_o && !res_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("timeout: no beat for %0d cycles, %0d results outstanding",
                 StallLimit, verdict_q.size());
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (res_valid_o && !res_stall_i) begin
        got = {visible_o, full_shadow_o, list_overflow_o};
        beats_seen++;
        vis_seen  += got.vis;
        full_seen += got.full;
        ovf_seen  += got.ovf;
        if (verdict_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected result beat %b at %0t", got, $realtime);
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("beat %0d: vis exp %b got %b, full exp %b got %b, ovf exp %b got %b",
                       beats_seen, want.vis, got.vis, want.full, got.full, want.ovf, got.ovf);
            end
          end
        end
      end
    end
  end

  initial begin
    int unsigned i;
    int unsigned pick;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    tile_valid_i  = 1'b0;
    new_octant_i  = 1'b0;
    tile_row_i    = '0;
    tile_col_i    = '0;
    opaque_tile_i = 1'b0;
    res_stall_i   = 1'b0;
    hold_left     = 0;
    shade_cnt     = 0;
    octant_dark   = 1'b0;
    dist_lim      = 9'd256;
    tiles_sent    = 0;
    beats_seen    = 0;
    vis_seen      = 0;
    full_seen     = 0;
    ovf_seen      = 0;
    mismatch_cnt  = 0;
    quiet_cycles  = 0;
    snd_idle_pct  = 32;
    rcv_idle_pct  = 77;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DirRows; i++) send_tile(DirTbl[i].req, DirTbl[i].known, DirTbl[i].want);

    // Distance limit sweep, extremes included.
    set_distance(9'd5);
    send_tile({1'b1, 8'd5, 8'd0, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0});
    send_tile({1'b0, 8'd4, 8'd0, 1'b0}, 1'b1, '{1'b1, 1'b0, 1'b0});
    set_distance(9'd0);
    send_tile({1'b1, 8'd0, 8'd0, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0});
    set_distance(9'd1);
    send_tile({1'b1, 8'd1, 8'd0, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0});
    send_tile({1'b0, 8'd0, 8'd3, 1'b0}, 1'b1, '{1'b1, 1'b0, 1'b0});
    set_distance(9'd511);
    send_tile({1'b1, 8'd255, 8'd0, 1'b0}, 1'b1, '{1'b1, 1'b0, 1'b0});
    set_distance(9'd256);

    // Random part in three stall profiles.
    fill_list();
    while (tiles_sent < RandTiles) begin
      if (tiles_sent > RandTiles / 3 && snd_idle_pct == 32) begin
        snd_idle_pct = 77;
        rcv_idle_pct = 32;
        set_distance(9'($urandom_range(1, 256)));
        fill_list();
      end else if (tiles_sent > 2 * RandTiles / 3 && snd_idle_pct == 77) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        set_distance(9'd256);
        // hold the result side off while tiles keep coming
        hold_left = HoldCycles;
      end
      pick = $urandom_range(99);
      if (pick < 80) send_octant();
      else send_noise();
    end

    tile_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run: %0d tiles, %0d results, %0d visible, %0d full-shadow, %0d dropped shadows",
             tiles_sent, beats_seen, vis_seen, full_seen, ovf_seen);
    $display("distance limits 0, 1, 5, 256, 511 and a random one; %0d mismatches",
             mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
